// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the sensor frame decoder.
// No dependencies; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while reset is asserted (active-low reset).
`define HSFD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define HSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HSFD_ASSERT(lbl, clk, rstn, prop, msg)
`define HSFD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/hsfd_pkg.sv =====
// Package for the sensor frame decoder: frame constants, status codes
// and the reflected CRC-16 byte update. No dependencies.
package hsfd_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_CODE = 8'h03;
    localparam logic [7:0]  LEN_CODE  = 8'h04;
    localparam logic [15:0] SIGN_BIT  = 16'h8000;
    localparam logic [15:0] MAG_MASK  = 16'h7FFF;

    // Byte positions within the eight-byte reply
    localparam logic [2:0] POS_FUNC    = 3'd0;
    localparam logic [2:0] POS_LEN     = 3'd1;
    localparam logic [2:0] POS_HUMI_HI = 3'd2;
    localparam logic [2:0] POS_HUMI_LO = 3'd3;
    localparam logic [2:0] POS_TEMP_HI = 3'd4;
    localparam logic [2:0] POS_TEMP_LO = 3'd5;
    localparam logic [2:0] POS_CRC_LO  = 3'd6;
    localparam logic [2:0] POS_CRC_HI  = 3'd7;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_HEADER = 2'd1,
        ST_CRC    = 2'd2
    } status_t;

    // One byte through the reflected CRC: eight unrolled shift/xor steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/humidity_sensor_frame_decoder_unit.sv =====
// Humidity sensor frame decoder, top level.
// Depends on hsfd_pkg.sv and assert_macros.svh.
//
// Decodes the eight-byte read reply of a temperature/humidity sensor that
// arrives one byte per input transaction (s_tdata = byte, s_tuser = start
// of frame). Bytes 0..5 run through a reflected CRC-16 (init 0xFFFF, poly
// 0xA001); byte 0 must be 0x03 and byte 1 must be 0x04; bytes 2,3 are the
// humidity word and bytes 4,5 the sign-magnitude temperature word (high
// byte first); bytes 6,7 carry the received CRC, low byte first. When byte
// 7 is taken, one result transaction follows on the next cycle: status
// (header error wins over CRC mismatch), signed temperature and humidity
// in tenths, and a below-zero flag. Error results carry zero data; a
// negative zero decodes to 0. The sign comes from each frame's own word.
// s_tuser high abandons a partial frame silently and takes the byte as
// byte 0; after byte 7 the next byte is byte 0 even without s_tuser.
// Rate: one byte per clock cycle while no result is stalled. The single
// output register is the only throttle: s_tready drops only while a result
// sits there untaken.
`include "assert_macros.svh"

module humidity_sensor_frame_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tuser,   // [0] frame_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [17:2] temperature_tenths,
                                   // [33:18] humidity_tenths, [34] below_zero,
                                   // [39:35] zero
);

    // Frame state
    logic [2:0]  pos_reg,    pos_next;
    logic [15:0] crc_reg,    crc_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [15:0] humi_reg,   humi_next;
    logic [15:0] temp_reg,   temp_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    hsfd_pkg::status_t    res_status_reg, res_status_next;
    logic signed [15:0]   res_temp_reg,   res_temp_next;
    logic [15:0]          res_humi_reg,   res_humi_next;
    logic                 res_below_reg,  res_below_next;

    // Working signals
    logic        in_acc;
    logic        last_byte_acc;
    logic [2:0]  pos_eff;      // position after a start flag is applied
    logic [15:0] crc_base;
    logic        hdr_base;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic [14:0] temp_mag;
    logic        temp_neg;
    logic signed [15:0] temp_dec;
    hsfd_pkg::status_t  status_dec;

    // Output slot free, or being drained this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    assign pos_eff  = s_tuser ? hsfd_pkg::POS_FUNC : pos_reg;
    assign crc_base = s_tuser ? hsfd_pkg::CRC_INIT : crc_reg;
    assign hdr_base = s_tuser ? 1'b1 : hdr_ok_reg;
    assign crc_upd  = hsfd_pkg::crc16_byte(crc_base, s_tdata);

    assign last_byte_acc = in_acc && (pos_eff == hsfd_pkg::POS_CRC_HI);

    // Result decode, valid when the last byte is on the input
    assign rx_crc   = {s_tdata, crc_lo_reg};
    assign temp_mag = temp_reg[14:0];
    assign temp_neg = ((temp_reg & hsfd_pkg::SIGN_BIT) != 16'h0000) && (temp_mag != 15'd0);
    assign temp_dec = temp_neg ? -$signed({1'b0, temp_mag}) : $signed({1'b0, temp_mag});

    always_comb begin
        if (!hdr_base) begin
            status_dec = hsfd_pkg::ST_HEADER;
        end else if (rx_crc != crc_base) begin
            status_dec = hsfd_pkg::ST_CRC;
        end else begin
            status_dec = hsfd_pkg::ST_OK;
        end
    end

    // Frame state update
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        hdr_ok_next = hdr_ok_reg;
        humi_next   = humi_reg;
        temp_next   = temp_reg;
        crc_lo_next = crc_lo_reg;
        if (in_acc) begin
            pos_next    = pos_eff + 3'd1;   // wraps to byte 0 after the last byte
            crc_next    = crc_base;
            hdr_ok_next = hdr_base;
            case (pos_eff)
                hsfd_pkg::POS_FUNC: begin
                    crc_next = crc_upd;
                    if (s_tdata != hsfd_pkg::FUNC_CODE) hdr_ok_next = 1'b0;
                end
                hsfd_pkg::POS_LEN: begin
                    crc_next = crc_upd;
                    if (s_tdata != hsfd_pkg::LEN_CODE) hdr_ok_next = 1'b0;
                end
                hsfd_pkg::POS_HUMI_HI: begin
                    crc_next  = crc_upd;
                    humi_next = {s_tdata, humi_reg[7:0]};
                end
                hsfd_pkg::POS_HUMI_LO: begin
                    crc_next  = crc_upd;
                    humi_next = {humi_reg[15:8], s_tdata};
                end
                hsfd_pkg::POS_TEMP_HI: begin
                    crc_next  = crc_upd;
                    temp_next = {s_tdata, temp_reg[7:0]};
                end
                hsfd_pkg::POS_TEMP_LO: begin
                    crc_next  = crc_upd;
                    temp_next = {temp_reg[15:8], s_tdata};
                end
                hsfd_pkg::POS_CRC_LO: begin
                    crc_lo_next = s_tdata;
                end
                hsfd_pkg::POS_CRC_HI: begin
                    // frame done: fresh CRC and header check
                    crc_next    = hsfd_pkg::CRC_INIT;
                    hdr_ok_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register update
    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        res_status_next = res_status_reg;
        res_temp_next   = res_temp_reg;
        res_humi_next   = res_humi_reg;
        res_below_next  = res_below_reg;
        if (last_byte_acc) begin
            out_valid_next  = 1'b1;
            res_status_next = status_dec;
            if (status_dec == hsfd_pkg::ST_OK) begin
                res_temp_next  = temp_dec;
                res_humi_next  = humi_reg;
                res_below_next = temp_neg;
            end else begin
                res_temp_next  = 16'sd0;
                res_humi_next  = 16'd0;
                res_below_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= hsfd_pkg::POS_FUNC;
            crc_reg       <= hsfd_pkg::CRC_INIT;
            hdr_ok_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            hdr_ok_reg    <= hdr_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: always written before being read within a frame
    always_ff @(posedge aclk) begin
        humi_reg       <= humi_next;
        temp_reg       <= temp_next;
        crc_lo_reg     <= crc_lo_next;
        res_status_reg <= res_status_next;
        res_temp_reg   <= res_temp_next;
        res_humi_reg   <= res_humi_next;
        res_below_reg  <= res_below_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, res_below_reg, res_humi_reg, res_temp_reg, res_status_reg};

    // Checks
    `HSFD_ASSERT(a_stall_blocks_input, aclk, aresetn,
        (out_valid_reg && !m_tready) |-> !s_tready, "input taken while result stalled")
    `HSFD_ASSERT(a_new_result_from_last_byte, aclk, aresetn,
        (out_valid_reg && !$past(out_valid_reg && !m_tready)) |-> $past(last_byte_acc),
        "result without a completed frame")
    `HSFD_ASSERT(a_below_zero_consistent, aclk, aresetn,
        out_valid_reg |-> (!res_below_reg ||
            (res_status_reg == hsfd_pkg::ST_OK && res_temp_reg[15])),
        "below_zero set on error or non-negative temperature")
    `HSFD_ASSERT(a_error_zero_data, aclk, aresetn,
        (out_valid_reg && res_status_reg != hsfd_pkg::ST_OK) |->
            (res_temp_reg == 16'sd0 && res_humi_reg == 16'd0),
        "error result carries data")
    `HSFD_ASSERT(a_frame_restart, aclk, aresetn,
        last_byte_acc |=> (pos_reg == hsfd_pkg::POS_FUNC && crc_reg == hsfd_pkg::CRC_INIT
            && hdr_ok_reg), "frame state not restarted after last byte")

endmodule
